// File: rtl/iol_pkg.sv
package iol_pkg;

  typedef enum logic [2:0] {
    CMD_GET       = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_INS_AT    = 3'd3,
    CMD_REM_AT    = 3'd4,
    CMD_REM_FRONT = 3'd5,
    CMD_REM_BACK  = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_EMPTY = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_kind_e;

  // Decoded action handed from the command decoder to the cell array
  typedef struct packed {
    op_kind_e kind;
    logic     rd_en;
    err_e     err;
  } op_t;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned LenW    = 5;
  localparam int unsigned InBytesW  = 40;
  localparam int unsigned OutBytesW = 40;

endpackage

// File: rtl/iol_dec.sv
module iol_dec import iol_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  cmd_e                            cmd_i,
  input  logic [PosW-1:0]                 pos_i,
  input  logic [$clog2(DEPTH+1)-1:0]      count_i,
  output op_t                             op_o,
  output logic [$clog2(DEPTH)-1:0]        idx_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  logic [CmpW-1:0] pos_w;
  logic [CmpW-1:0] cnt_w;
  logic            full;
  logic            empty;
  logic [IdxW-1:0] pos_idx;
  logic [IdxW-1:0] cnt_idx;
  logic [IdxW-1:0] last_idx;

  assign pos_w    = CmpW'(pos_i);
  assign cnt_w    = CmpW'(count_i);
  assign full     = (count_i == CntW'(DEPTH));
  assign empty    = (count_i == '0);
  assign pos_idx  = pos_w[IdxW-1:0];
  assign cnt_idx  = cnt_w[IdxW-1:0];
  assign last_idx = cnt_idx - IdxW'(1);

  always_comb begin
    op_o.kind  = OP_HOLD;
    op_o.rd_en = 1'b0;
    op_o.err   = ERR_OK;
    idx_o      = '0;
    unique case (cmd_i)
      CMD_GET: begin
        idx_o = pos_idx;
        if (pos_w < cnt_w) op_o.rd_en = 1'b1;
        else op_o.err = ERR_RANGE;
      end
      CMD_INS_FRONT: begin
        if (full) op_o.err = ERR_FULL;
        else op_o.kind = OP_INSERT;
      end
      CMD_INS_BACK: begin
        idx_o = cnt_idx;
        if (full) op_o.err = ERR_FULL;
        else op_o.kind = OP_INSERT;
      end
      CMD_INS_AT: begin
        idx_o = pos_idx;
        // range check wins over the full check
        if (pos_w > cnt_w) op_o.err = ERR_RANGE;
        else if (full) op_o.err = ERR_FULL;
        else op_o.kind = OP_INSERT;
      end
      CMD_REM_AT: begin
        idx_o = pos_idx;
        if (empty) op_o.err = ERR_EMPTY;
        else if (pos_w >= cnt_w) op_o.err = ERR_RANGE;
        else op_o.kind = OP_REMOVE;
      end
      CMD_REM_FRONT: begin
        if (empty) op_o.err = ERR_EMPTY;
        else op_o.kind = OP_REMOVE;
      end
      CMD_REM_BACK: begin
        idx_o = last_idx;
        if (empty) op_o.err = ERR_EMPTY;
        else op_o.kind = OP_REMOVE;
      end
      CMD_CLEAR: op_o.kind = OP_CLEAR;
      default: op_o.kind = OP_HOLD;
    endcase
  end

endmodule

// File: rtl/iol_cells.sv
module iol_cells import iol_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  op_t                         op_i,
  input  logic [$clog2(DEPTH)-1:0]    idx_i,
  input  logic [VALUE_WIDTH-1:0]      val_i,
  output logic [$clog2(DEPTH+1)-1:0]  count_o,
  output logic [VALUE_WIDTH-1:0]      rd_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(DEPTH);
  // a position field can only reach the first 32 cells
  localparam int unsigned ReadN = (DEPTH < 32) ? DEPTH : 32;
  localparam int unsigned RdW   = $clog2(ReadN);

  logic [VALUE_WIDTH-1:0] cell_q [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_d [DEPTH];
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        count_d;

  // Each cell loads from its lower or upper neighbor, takes the new value, or holds
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_d[i] = cell_q[i];
      unique case (op_i.kind)
        OP_INSERT: begin
          if (IdxW'(i) == idx_i) cell_d[i] = val_i;
          else if ((i > 0) && (IdxW'(i) > idx_i)) cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
        OP_REMOVE: begin
          if ((i < DEPTH - 1) && (IdxW'(i) >= idx_i)) begin
            cell_d[i] = cell_q[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
        default: cell_d[i] = cell_q[i];
      endcase
    end
  end

  always_comb begin
    unique case (op_i.kind)
      OP_INSERT: count_d = count_q + CntW'(1);
      OP_REMOVE: count_d = count_q - CntW'(1);
      OP_CLEAR:  count_d = '0;
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

  // cells at or beyond the count are never read, so they need no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DEPTH; i++) cell_q[i] <= cell_d[i];
    end
  end

  assign count_o = count_q;
  assign rd_o    = op_i.rd_en ? cell_q[idx_i[RdW-1:0]] : '0;

endmodule

// File: rtl/indexed_ordered_list.sv
// Channel   Dir  Bits  Contents (lowest bit up)
// s_axis    in   40    command[2:0] position[7:3] item_value[39:8]
// m_axis    out  40    read_value[31:0] list_length[36:32] list_empty[37] error_code[39:38]
//
// One command per cycle unless the result side stalls; a command passes through the
// input register and then the result register. The list update happens as it moves
// from the one into the other, so the command after it sees the new list.
// Reset clears the entry count; the cells themselves are not cleared.
// A stalled result holds the result register; once the input register also holds
// a command, s_axis_tready drops until the result is taken.
module indexed_ordered_list import iol_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InBytesW-1:0]  s_axis_tdata_i,  // command, position, item_value
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutBytesW-1:0] m_axis_tdata_o   // read_value, list_length, list_empty,
                                                // error_code
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  logic                   in_vld_q;
  cmd_e                   cmd_q;
  logic [PosW-1:0]        pos_q;
  logic [DataW-1:0]       val_q;

  logic                   out_vld_q;
  logic [DataW-1:0]       rd_q;
  logic [LenW-1:0]        len_q;
  logic                   empty_q;
  err_e                   err_q;

  logic                   adv;
  logic                   upd;
  op_t                    op;
  logic [IdxW-1:0]        idx;
  logic [CntW-1:0]        count;
  logic [CntW-1:0]        count_next;
  logic [VALUE_WIDTH-1:0] cell_rd;
  logic [63:0]            rd_wide;
  op_t                    op_gated;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign upd             = adv && in_vld_q;
  assign s_axis_tready_o = !in_vld_q || adv;

  iol_dec #(.DEPTH(DEPTH)) u_dec (
    .cmd_i   (cmd_q),
    .pos_i   (pos_q),
    .count_i (count),
    .op_o    (op),
    .idx_o   (idx)
  );

  // no shift or clear unless the command really moves on; the read port is not gated
  always_comb begin
    op_gated = op;
    if (!upd) begin
      op_gated.kind  = OP_HOLD;
    end
  end

  iol_cells #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_cells (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (upd),
    .op_i    (op_gated),
    .idx_i   (idx),
    .val_i   (VALUE_WIDTH'(val_q)),
    .count_o (count),
    .rd_o    (cell_rd)
  );

  assign rd_wide = 64'(cell_rd);

  always_comb begin
    unique case (op.kind)
      OP_INSERT: count_next = count + CntW'(1);
      OP_REMOVE: count_next = count - CntW'(1);
      OP_CLEAR:  count_next = '0;
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      cmd_q <= cmd_e'(s_axis_tdata_i[CmdW-1:0]);
      pos_q <= s_axis_tdata_i[CmdW +: PosW];
      val_q <= s_axis_tdata_i[CmdW + PosW +: DataW];
    end
    if (upd) begin
      rd_q    <= rd_wide[DataW-1:0];
      len_q   <= LenW'(count_next);
      empty_q <= (count_next == '0);
      err_q   <= op.err;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {err_q, empty_q, len_q, rd_q};

endmodule

// File: bench/iol_result_checker.sv
module iol_result_checker import iol_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  logic                 cmd_ready_i,
  input  logic [InBytesW-1:0]  cmd_data_i,   // command, position, item_value
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [OutBytesW-1:0] res_data_i,   // read_value, list_length, list_empty,
                                             // error_code
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned ListDepth  = 16;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [DataW-1:0] read_value;
    logic [LenW-1:0]  list_length;
    logic             list_empty;
    err_e             error_code;
  } list_result_t;

  logic [DataW-1:0] shadow_cells [ListDepth];
  int unsigned      shadow_count;
  list_result_t     expected_results [$];
  int unsigned      result_index;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    result_index = 0;
  end

  // Shift entries at and above the slot up by one and store the new value
  function automatic void open_slot(int unsigned slot, logic [DataW-1:0] value);
    for (int unsigned i = shadow_count; i > slot; i--) begin
      shadow_cells[i] = shadow_cells[i-1];
    end
    shadow_cells[slot] = value;
    shadow_count++;
  endfunction

  // Shift entries above the slot down by one; zero the freed top slot
  function automatic void close_slot(int unsigned slot);
    for (int unsigned i = slot; i + 1 < shadow_count; i++) begin
      shadow_cells[i] = shadow_cells[i+1];
    end
    shadow_count--;
    shadow_cells[shadow_count] = '0;
  endfunction

  function automatic list_result_t predict_list_op(cmd_e cmd, logic [PosW-1:0] pos,
                                                   logic [DataW-1:0] value);
    list_result_t res;
    res.read_value = '0;
    res.error_code = ERR_OK;
    case (cmd)
      CMD_GET: begin
        if (pos < shadow_count) res.read_value = shadow_cells[pos];
        else res.error_code = ERR_RANGE;
      end
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (shadow_count >= ListDepth) res.error_code = ERR_FULL;
        else open_slot((cmd == CMD_INS_FRONT) ? 0 : shadow_count, value);
      end
      CMD_INS_AT: begin
        if (pos > shadow_count) res.error_code = ERR_RANGE;
        else if (shadow_count >= ListDepth) res.error_code = ERR_FULL;
        else open_slot(pos, value);
      end
      CMD_REM_AT: begin
        if (shadow_count == 0) res.error_code = ERR_EMPTY;
        else if (pos >= shadow_count) res.error_code = ERR_RANGE;
        else close_slot(pos);
      end
      CMD_REM_FRONT, CMD_REM_BACK: begin
        if (shadow_count == 0) res.error_code = ERR_EMPTY;
        else close_slot((cmd == CMD_REM_FRONT) ? 0 : shadow_count - 1);
      end
      default: begin
        shadow_count = 0;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
      end
    endcase
    res.list_length = shadow_count[LenW-1:0];
    res.list_empty  = (shadow_count == 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    list_result_t got;
    if (!rst_ni) begin
      expected_results.delete();
      shadow_count = 0;
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      pending_o = 0;
    end else begin
      // retire the result beat first: its command was taken before it, so its prediction is already queued
      if (res_valid_i && res_ready_i) begin
        got.read_value  = res_data_i[31:0];
        got.list_length = res_data_i[36:32];
        got.list_empty  = res_data_i[37];
        got.error_code  = err_e'(res_data_i[39:38]);
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax)
            $display("result %0d arrived with nothing outstanding: %h", result_index,
                     res_data_i);
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value || got.list_length !== want.list_length ||
              got.list_empty !== want.list_empty || got.error_code !== want.error_code) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax)
              $display("result %0d mismatch: expected value %h len %0d empty %b err %s",
                       result_index, want.read_value, want.list_length, want.list_empty,
                       want.error_code.name(),
                       ", got value %h len %0d empty %b err %s",
                       got.read_value, got.list_length, got.list_empty,
                       got.error_code.name());
          end
        end
        result_index++;
      end
      if (cmd_valid_i && cmd_ready_i) begin
        expected_results.push_back(predict_list_op(cmd_e'(cmd_data_i[2:0]),
                                                   cmd_data_i[7:3], cmd_data_i[39:8]));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: bench/tb_indexed_ordered_list.sv
module tb_indexed_ordered_list;
  import iol_pkg::*;

  localparam int unsigned RandomItems = 1630;
  localparam int unsigned HoldAt      = 900;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InBytesW-1:0]  s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutBytesW-1:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  always #6 clk_i = ~clk_i;

  indexed_ordered_list i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  iol_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_tvalid),
    .cmd_ready_i  (s_tready),
    .cmd_data_i   (s_tdata),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[indexed_ordered_list] ERROR");
      $finish;
    end
  end

  // Result side: random backpressure, one long hold-off while commands keep coming
  initial begin
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_off && sent_count >= HoldAt) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        held_off = 1'b1;
      end else begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send_command(cmd_e cmd, logic [PosW-1:0] pos, logic [DataW-1:0] value);
    while (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {value, pos, cmd};
    do @(posedge clk_i); while (!s_tready);
    sent_count++;
  endtask

  function automatic cmd_e pick_command(mix_e mix);
    int unsigned r;
    int unsigned ins_share;
    int unsigned get_share;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin ins_share = 60; get_share = 15; end
      MIX_DRAIN: begin ins_share = 20; get_share = 15; end
      default:   begin ins_share = 40; get_share = 20; end
    endcase
    if (r < ins_share) return cmd_e'(int'(CMD_INS_FRONT) + $urandom_range(2));
    if (r < ins_share + get_share) return CMD_GET;
    if (r < 97) return cmd_e'(int'(CMD_REM_AT) + $urandom_range(2));
    return CMD_CLEAR;
  endfunction

  function automatic logic [PosW-1:0] pick_position();
    if ($urandom_range(1) == 0) return PosW'($urandom_range(16));
    return PosW'($urandom_range(3));
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    mix_e mix;
    mix = MIX_FILL;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-list corner cases
    send_command(CMD_GET,       5'd0,  32'h1111_1111);
    send_command(CMD_REM_AT,    5'd0,  '0);
    send_command(CMD_REM_FRONT, 5'd0,  '0);
    send_command(CMD_REM_BACK,  5'd0,  '0);
    send_command(CMD_CLEAR,     5'd0,  '0);
    send_command(CMD_INS_AT,    5'd1,  32'hDEAD_BEEF);
    // build a short list through every insert kind
    send_command(CMD_INS_AT,    5'd0,  32'hFFFF_FFFF);
    send_command(CMD_INS_FRONT, 5'd31, 32'h0000_0000);
    send_command(CMD_INS_BACK,  5'd16, 32'hA5A5_5A5A);
    send_command(CMD_INS_AT,    5'd3,  32'h8000_0001);
    send_command(CMD_INS_AT,    5'd2,  32'h1234_5678);
    send_command(CMD_GET,       5'd0,  '0);
    send_command(CMD_GET,       5'd4,  '0);
    send_command(CMD_GET,       5'd5,  '0);
    send_command(CMD_GET,       5'd16, '0);
    send_command(CMD_INS_AT,    5'd6,  32'h5555_AAAA);
    // removals, including one past the end
    send_command(CMD_REM_AT,    5'd5,  '0);
    send_command(CMD_REM_AT,    5'd1,  '0);
    send_command(CMD_REM_FRONT, 5'd0,  '0);
    send_command(CMD_REM_BACK,  5'd0,  '0);
    send_command(CMD_GET,       5'd1,  '0);
    send_command(CMD_CLEAR,     5'd0,  '0);
    send_command(CMD_GET,       5'd0,  '0);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) mix = mix_e'($urandom_range(2));
      calm = (i >= 250 && i < 450);
      send_command(pick_command(mix), pick_position(), pick_value());
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[indexed_ordered_list] OK");
    end else begin
      $display("[indexed_ordered_list] ERROR");
    end
    $finish;
  end

endmodule
